// File: sv/assert_macros.svh
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ple: assertion failed");

`define PLE_NEVER(lbl, clk, rst_n, cond) \
  `PLE_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define PLE_ASSERT(lbl, clk, rst_n, prop)

`define PLE_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: sv/ple_pkg.sv
package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int OUT_W  = 6;
  localparam int OP_W   = 3;
  localparam int STS_W  = 3;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

  localparam logic [STS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [OUT_W-1:0] found_position;
    logic [OUT_W-1:0] item_count;
  } res_t;

endpackage

// File: sv/ple_store.sv
module ple_store import ple_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ple_seq.sv
module ple_seq import ple_pkg::*; #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] val,
  input  logic [POS_W-1:0]         pos,
  output logic                     ready,
  output logic                     res_valid,
  output res_t                     res,
  input  logic                     res_taken,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic signed [DATA_W-1:0] mem_rdata
);

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     pend_r, pend_nxt;
  logic [CW-1:0]            ptr_r, ptr_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            wa_r, wa_nxt;
  logic [CW-1:0]            found_r, found_nxt;
  logic [STS_W-1:0]         status_r, status_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic [CW-1:0]   pos_m1, ptr_dec, ptr_inc;
  logic            match;

  assign pos_x   = CMPW'(pos);
  assign cnt_x   = CMPW'(count_r);
  assign pos_m1  = CW'(pos_x - CMPW'(1));
  assign ptr_dec = ptr_r - CW'(1);
  assign ptr_inc = ptr_r + CW'(1);
  assign match   = pend_r && (mem_rdata == val_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pend_nxt   = 1'b0;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    wa_nxt     = wa_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    val_nxt    = val_r;
    mem_we     = 1'b0;
    mem_waddr  = AW'(wa_r);
    mem_wdata  = mem_rdata;
    mem_raddr  = AW'(ptr_r);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt    = val;
          found_nxt  = '0;
          status_nxt = ST_DONE;
          state_nxt  = S_RES;
          case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (op == OP_INS_AT &&
                  (pos_x == '0 || pos_x > cnt_x + CMPW'(1))) begin
                status_nxt = ST_BADPOS;
              end else if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_INS;
                ptr_nxt   = count_r;
                if (op == OP_INS_FRONT) begin
                  idx_nxt = '0;
                end else if (op == OP_INS_BACK) begin
                  idx_nxt = count_r;
                end else begin
                  idx_nxt = pos_m1;
                end
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (op == OP_DEL_AT && (pos_x == '0 || pos_x > cnt_x)) begin
                status_nxt = ST_BADPOS;
              end else begin
                state_nxt = S_DEL;
                if (op == OP_DEL_FRONT) begin
                  ptr_nxt = CW'(1);
                end else if (op == OP_DEL_BACK) begin
                  ptr_nxt = count_r;
                end else begin
                  ptr_nxt = CW'(pos);
                end
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SRCH;
                ptr_nxt   = '0;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      // shift entries up from the tail, then drop the new value into the gap
      S_INS: begin
        if (ptr_r > idx_r) begin
          mem_raddr = AW'(ptr_dec);
          pend_nxt  = 1'b1;
          wa_nxt    = ptr_r;
          ptr_nxt   = ptr_dec;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wa_r);
          mem_wdata = mem_rdata;
        end else if (!(ptr_r > idx_r)) begin
          mem_we     = 1'b1;
          mem_waddr  = AW'(idx_r);
          mem_wdata  = val_r;
          count_nxt  = count_r + CW'(1);
          status_nxt = ST_DONE;
          state_nxt  = S_RES;
        end
      end
      // shift entries down over the removed slot
      S_DEL: begin
        if (ptr_r < count_r) begin
          mem_raddr = AW'(ptr_r);
          pend_nxt  = 1'b1;
          wa_nxt    = ptr_dec;
          ptr_nxt   = ptr_inc;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wa_r);
          mem_wdata = mem_rdata;
        end else if (!(ptr_r < count_r)) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_DONE;
          state_nxt  = S_RES;
        end
      end
      S_SRCH: begin
        if (match) begin
          found_nxt  = wa_r + CW'(1);
          status_nxt = ST_DONE;
          state_nxt  = S_RES;
        end else if (ptr_r < count_r) begin
          mem_raddr = AW'(ptr_r);
          pend_nxt  = 1'b1;
          wa_nxt    = ptr_r;
          ptr_nxt   = ptr_inc;
        end else if (!pend_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RES;
        end
      end
      S_RES: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    wa_r     <= wa_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
  end

  assign ready              = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_RES);
  assign res.status         = status_r;
  assign res.found_position = OUT_W'(found_r);
  assign res.item_count     = OUT_W'(count_r);

endmodule

// File: sv/positional_list_engine.sv
// Channel   Ports                                                               Dir
// input     in_valid in_stall in_opcode in_value in_position                    in
// result    out_valid out_stall out_status out_found_position out_item_count    out
//
// One operation at a time through an element store with one read and one write port.
// Insert shifts entries from the tail up to the insert index, then writes the new value;
// delete shifts the entries behind the removed slot down; search reads entries from the
// front until one matches. Rejected ops and opcode 7 touch no entries. Each result is
// then loaded into the result register.
// Synchronous active-low reset empties the list; store contents are not cleared.
// A result stalled at the output holds the result register; the next input transfer
// is taken meanwhile and its result waits until the register frees.
`include "assert_macros.svh"

module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STS_W-1:0]         out_status,
  output logic [OUT_W-1:0]         out_found_position,
  output logic [OUT_W-1:0]         out_item_count
);

  localparam int AW = $clog2(CAPACITY);

  logic                     ready;
  logic                     res_valid;
  res_t                     res;
  logic                     res_load;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  ple_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && ready),
    .op        (in_opcode),
    .val       (in_value),
    .pos       (in_position),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_load),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ple_store #(.DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_load = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign in_stall           = !ready;
  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_found_position = out_res_r.found_position;
  assign out_item_count     = out_res_r.item_count;

  `PLE_ASSERT(a_busy_after_xfer, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `PLE_ASSERT(a_res_to_out, clk, rst_n, res_load |=> out_valid)
  `PLE_NEVER(a_found_only_done, clk, rst_n,
             out_valid && out_found_position != '0 && out_status != ST_DONE)

endmodule

// File: tb/sv/positional_list_engine_tb.sv
`timescale 1ns / 100ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int LIST_CAP = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic [OP_W-1:0] OP_NOP = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    bit                       drain;
  } list_cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STS_W-1:0] out_status;
  logic [OUT_W-1:0] out_found_position;
  logic [OUT_W-1:0] out_item_count;

  list_cmd_t cmd_queue[$];
  res_t expected_results[$];
  logic signed [DATA_W-1:0] list_model[$];
  res_t want_res;

  int gen_depth = 0;
  int deepest_list = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int ops_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int status_hist[8];

  positional_list_engine uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_position(out_found_position),
    .out_item_count(out_item_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Applies one operation to the list copy and returns the result it yields.
  function automatic res_t predict_list_op(list_cmd_t c);
    res_t r;
    int cnt;
    int idx;
    r.status = ST_DONE;
    r.found_position = '0;
    cnt = list_model.size();
    case (c.op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (c.op == OP_INS_FRONT) idx = 0;
        else if (c.op == OP_INS_BACK) idx = cnt;
        else idx = int'(c.pos) - 1;
        if (c.op == OP_INS_AT && (c.pos == 0 || int'(c.pos) > cnt + 1)) r.status = ST_BADPOS;
        else if (cnt >= LIST_CAP) r.status = ST_FULL;
        else list_model.insert(idx, c.value);
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (cnt == 0) r.status = ST_EMPTY;
        else if (c.op == OP_DEL_AT && (c.pos == 0 || int'(c.pos) > cnt)) r.status = ST_BADPOS;
        else if (c.op == OP_DEL_FRONT) list_model.delete(0);
        else if (c.op == OP_DEL_BACK) list_model.delete(cnt - 1);
        else list_model.delete(int'(c.pos) - 1);
      end
      OP_SEARCH: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < cnt; i++) begin
            if (r.status == ST_NOTFOUND && list_model[i] == c.value) begin
              r.status = ST_DONE;
              r.found_position = OUT_W'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    r.item_count = OUT_W'(list_model.size());
    if (list_model.size() > deepest_list) deepest_list = list_model.size();
    return r;
  endfunction

  // Length of the list after an operation; only used to aim the stimulus.
  function automatic int count_after(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, int cnt);
    case (op)
      OP_INS_FRONT, OP_INS_BACK: return (cnt < LIST_CAP) ? cnt + 1 : cnt;
      OP_INS_AT: return (pos != 0 && int'(pos) <= cnt + 1 && cnt < LIST_CAP) ? cnt + 1 : cnt;
      OP_DEL_FRONT, OP_DEL_BACK: return (cnt > 0) ? cnt - 1 : cnt;
      OP_DEL_AT: return (pos != 0 && int'(pos) <= cnt) ? cnt - 1 : cnt;
      default: return cnt;
    endcase
  endfunction

  // Small pool so that searches hit and duplicates occur.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5, 6: return DATA_W'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                         logic [POS_W-1:0] pos, bit drain);
    list_cmd_t c;
    c.op = op;
    c.value = value;
    c.pos = pos;
    c.drain = drain;
    cmd_queue.push_back(c);
    gen_depth = count_after(op, pos, gen_depth);
  endtask

  // Phases that fill, drain or churn the list, with some noise mixed in.
  task automatic gen_random(int n);
    int phase_left;
    int ins_pct;
    int del_pct;
    int r;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    phase_left = 0;
    ins_pct = 40;
    del_pct = 35;
    for (int k = 0; k < n; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 80);
        case ($urandom_range(0, 2))
          0: begin ins_pct = 70; del_pct = 10; end
          1: begin ins_pct = 15; del_pct = 65; end
          default: begin ins_pct = 40; del_pct = 35; end
        endcase
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_cmd(OP_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom_range(0, 255)),
                k == n / 2);
      end else if (r < 5 + ins_pct) begin
        op = OP_W'($urandom_range(0, 2));
        pos = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(1, gen_depth + 1))
                                          : POS_W'($urandom_range(0, 255));
        add_cmd(op, pick_value(), pos, k == n / 2);
      end else if (r < 5 + ins_pct + del_pct) begin
        op = OP_W'($urandom_range(3, 5));
        pos = ($urandom_range(0, 99) < 85)
              ? POS_W'($urandom_range(1, (gen_depth == 0) ? 1 : gen_depth))
              : POS_W'($urandom_range(0, 255));
        add_cmd(op, $urandom, pos, k == n / 2);
      end else begin
        add_cmd(OP_SEARCH, pick_value(), POS_W'($urandom_range(0, 255)), k == n / 2);
      end
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(predict_list_op(cmd_queue.pop_front()));
        ops_sent++;
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0 &&
                   (!cmd_queue[0].drain || expected_results.size() == 0)) begin
        in_valid <= 1'b1;
        in_opcode <= cmd_queue[0].op;
        in_value <= cmd_queue[0].value;
        in_position <= cmd_queue[0].pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and result-side stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: status %0d found %0d count %0d",
                     out_status, out_found_position, out_item_count);
        end else begin
          want_res = expected_results.pop_front();
          results_checked++;
          status_hist[out_status]++;
          if (out_status !== want_res.status ||
              out_found_position !== want_res.found_position ||
              out_item_count !== want_res.item_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: expected status %0d found %0d count %0d, got %0d %0d %0d",
                       results_checked, want_res.status, want_res.found_position,
                       want_res.item_count, out_status, out_found_position, out_item_count);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL positional_list_engine");
      $finish;
    end
  end

  initial begin
    // Empty-list cases
    add_cmd(OP_SEARCH, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_DEL_FRONT, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_DEL_BACK, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_DEL_AT, 32'sd0, 8'd1, 1'b0);
    add_cmd(OP_INS_AT, 32'sd5, 8'd2, 1'b0);
    add_cmd(OP_INS_AT, 32'sd5, 8'd0, 1'b0);
    add_cmd(OP_NOP, 32'sd0, 8'd0, 1'b0);
    // Build a short list with extreme values, then search it and delete from it
    add_cmd(OP_INS_FRONT, 32'sh8000_0000, 8'd0, 1'b0);
    add_cmd(OP_INS_BACK, 32'sh7fff_ffff, 8'd0, 1'b0);
    add_cmd(OP_INS_AT, -32'sd1, 8'd3, 1'b0);
    add_cmd(OP_INS_AT, 32'sd0, 8'd1, 1'b0);
    add_cmd(OP_INS_AT, 32'sd9, 8'd255, 1'b0);
    add_cmd(OP_SEARCH, 32'sh7fff_ffff, 8'd0, 1'b0);
    add_cmd(OP_SEARCH, 32'sd12345, 8'd0, 1'b0);
    add_cmd(OP_DEL_AT, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_DEL_AT, 32'sd0, 8'd5, 1'b0);
    add_cmd(OP_DEL_AT, 32'sd0, 8'd2, 1'b0);
    add_cmd(OP_DEL_FRONT, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_SEARCH, -32'sd1, 8'd0, 1'b0);
    add_cmd(OP_DEL_BACK, 32'sd0, 8'd0, 1'b0);
    add_cmd(OP_NOP, -32'sd1, 8'd255, 1'b0);
    add_cmd(OP_SEARCH, 32'sh7fff_ffff, 8'd0, 1'b1);
    gen_random(RANDOM_ITEMS);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d list operations sent, %0d results checked, deepest list %0d of %0d",
             ops_sent, results_checked, deepest_list, LIST_CAP);
    $display("status mix: done %0d, empty %0d, bad position %0d, full %0d, not found %0d",
             status_hist[ST_DONE], status_hist[ST_EMPTY], status_hist[ST_BADPOS],
             status_hist[ST_FULL], status_hist[ST_NOTFOUND]);
    if (mismatches == 0) begin
      $display("PASS positional_list_engine");
    end else begin
      $display("FAIL positional_list_engine");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ple_pkg.sv
sv/ple_store.sv
sv/ple_seq.sv
sv/positional_list_engine.sv
tb/sv/positional_list_engine_tb.sv
